// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SEM_ASSERT_IMM(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sem: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SEM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sem: next-cycle check failed");

`endif

// ===== hw/rtl/sem_pkg.sv =====
`timescale 1ns / 1ps
package sem_pkg;

  localparam int PIX_W         = 8;
  localparam int MAG_W         = 8;
  localparam int WIDTH_W       = 11;
  localparam int HEIGHT_W      = 13;
  localparam int ROW_W         = 12;
  localparam int CFG_DATA_W    = 13;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int NUM_KINDS     = 4;
  localparam int SUM_W         = PIX_W + 2;
  localparam int DIV_SH        = 3;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Which output position a result stands for, relative to the input pixel.
  typedef enum logic [1:0] {
    RK_INTERIOR = 2'd0,
    RK_RIGHT    = 2'd1,
    RK_BOTTOM   = 2'd2,
    RK_CORNER   = 2'd3
  } res_kind_t;

  // Index 0 is the row two above, 1 the row above, 2 the current row.
  typedef logic [2:0][PIX_W-1:0] pix_col_t;
  // Window indexed [row][column], column 2 being the newest.
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic valid;
    logic last_col;
    logic last_row;
  } col_ctl_t;

  function automatic logic [MAG_W-1:0] sobel_mag(input win_t w);
    logic [SUM_W-1:0] gx_p;
    logic [SUM_W-1:0] gx_n;
    logic [SUM_W-1:0] gy_p;
    logic [SUM_W-1:0] gy_n;
    logic [SUM_W-1:0] ax;
    logic [SUM_W-1:0] ay;
    gx_p = SUM_W'(w[0][2]) + SUM_W'({w[1][2], 1'b0}) + SUM_W'(w[2][2]);
    gx_n = SUM_W'(w[0][0]) + SUM_W'({w[1][0], 1'b0}) + SUM_W'(w[2][0]);
    gy_p = SUM_W'(w[2][0]) + SUM_W'({w[2][1], 1'b0}) + SUM_W'(w[2][2]);
    gy_n = SUM_W'(w[0][0]) + SUM_W'({w[0][1], 1'b0}) + SUM_W'(w[0][2]);
    ax   = (gx_p >= gx_n) ? gx_p - gx_n : gx_n - gx_p;
    ay   = (gy_p >= gy_n) ? gy_p - gy_n : gy_n - gy_p;
    return MAG_W'(ax[SUM_W-1:DIV_SH]) + MAG_W'(ay[SUM_W-1:DIV_SH]);
  endfunction

endpackage

// ===== hw/rtl/sem_ram.sv =====
`timescale 1ns / 1ps
module sem_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/sem_line_fetch.sv =====
`timescale 1ns / 1ps
module sem_line_fetch import sem_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  output col_ctl_t              col_ctl,
  input  logic                  col_ready,
  output pix_col_t              col_pix,
  output logic [ROW_W-1:0]      col_row,
  output logic [COL_W-1:0]      col_col
);

  localparam int LIM_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int ENT_W = 2 * PIX_W;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [ROW_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]    col_cnt_r, col_cnt_nxt;
  logic [LIM_W-1:0]    w_ext, w_lim;
  logic [HEIGHT_W-1:0] h_lim;
  logic                last_col_in, last_row_in;
  logic                accept, s1_adv;

  logic                s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]    px_s1_r;
  logic [ROW_W-1:0]    row_s1_r;
  logic [COL_W-1:0]    col_s1_r;
  logic                last_col_s1_r, last_row_s1_r;

  logic                fwd_r;
  logic [ENT_W-1:0]    fwd_data_r;
  logic [ENT_W-1:0]    ram_rdata, ram_wdata, ent_rd;
  logic [PIX_W-1:0]    top_px, mid_px;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size as used by the counters: zero counts as one, and the
  // width is capped at the line store depth.
  always_comb begin
    w_ext = LIM_W'(width_r);
    if (w_ext == '0) begin
      w_lim = LIM_W'(1);
    end else if (w_ext > LIM_W'(MAX_WIDTH)) begin
      w_lim = LIM_W'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    if (height_r == '0) begin
      h_lim = HEIGHT_W'(1);
    end else if (height_r > HEIGHT_W'(MAX_HEIGHT)) begin
      h_lim = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_lim = height_r;
    end
  end

  assign last_col_in = (LIM_W'(col_cnt_r) + LIM_W'(1)) >= w_lim;
  assign last_row_in = (HEIGHT_W'(row_cnt_r) + HEIGHT_W'(1)) >= h_lim;

  assign s1_adv   = s1_valid_r && col_ready;
  assign in_ready = !s1_valid_r || col_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (accept) begin
      if (last_col_in) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row_in ? '0 : row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_cnt_r  <= row_cnt_nxt;
      col_cnt_r  <= col_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // The item leaving this stage writes its column back in the same cycle
  // the next item reads; on a single-column frame both hit one entry, so
  // the written data is kept and used in place of the stale read.
  always_ff @(posedge clk) begin
    if (accept) begin
      px_s1_r       <= in_pixel;
      row_s1_r      <= row_cnt_r;
      col_s1_r      <= col_cnt_r;
      last_col_s1_r <= last_col_in;
      last_row_s1_r <= last_row_in;
      fwd_r         <= s1_adv && (col_s1_r == col_cnt_r);
      fwd_data_r    <= ram_wdata;
    end
  end

  assign ent_rd    = fwd_r ? fwd_data_r : ram_rdata;
  // The top row stands in for the rows above it.
  assign top_px    = (row_s1_r == '0) ? px_s1_r : ent_rd[ENT_W-1:PIX_W];
  assign mid_px    = (row_s1_r == '0) ? px_s1_r : ent_rd[PIX_W-1:0];
  assign ram_wdata = {mid_px, px_s1_r};

  sem_ram #(
    .DATA_W(ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(col_s1_r),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(col_cnt_r),
    .rdata(ram_rdata)
  );

  assign col_ctl.valid    = s1_valid_r;
  assign col_ctl.last_col = last_col_s1_r;
  assign col_ctl.last_row = last_row_s1_r;
  assign col_pix[0]       = top_px;
  assign col_pix[1]       = mid_px;
  assign col_pix[2]       = px_s1_r;
  assign col_row          = row_s1_r;
  assign col_col          = col_s1_r;

endmodule

// ===== hw/rtl/sem_window_out.sv =====
`timescale 1ns / 1ps
module sem_window_out import sem_pkg::*; #(
  parameter int COL_W = $clog2(DEF_MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  col_ctl_t           col_ctl,
  output logic               col_ready,
  input  pix_col_t           col_pix,
  input  logic [ROW_W-1:0]   col_row,
  input  logic [COL_W-1:0]   col_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [MAG_W-1:0]   out_magnitude,
  output logic [ROW_W-1:0]   out_row,
  output logic [COL_W-1:0]   out_col,
  output logic               out_last,
  output logic               out_end_of_frame
);

  win_t                 win_r, win_nxt, rows_w, eff_win;
  logic [NUM_KINDS-1:0] pend_r, pend_nxt, rest, mask;
  logic [ROW_W-1:0]     row_s2_r;
  logic [COL_W-1:0]     col_s2_r;
  res_kind_t            kind;
  logic                 row_sh, col_sh;
  logic                 emit, s2_free, load, first_col, first_row;

  logic                 out_valid_r;
  logic [MAG_W-1:0]     out_mag_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [COL_W-1:0]     out_col_r;
  logic                 out_last_r, out_eof_r;

  assign emit = (pend_r != '0) && (!out_valid_r || out_ready);

  // Results of one item go out in a fixed order: interior, right border,
  // bottom border, corner.
  always_comb begin
    if (pend_r[RK_INTERIOR]) begin
      kind = RK_INTERIOR;
    end else if (pend_r[RK_RIGHT]) begin
      kind = RK_RIGHT;
    end else if (pend_r[RK_BOTTOM]) begin
      kind = RK_BOTTOM;
    end else begin
      kind = RK_CORNER;
    end
    rest       = pend_r;
    rest[kind] = 1'b0;
  end

  assign s2_free   = (pend_r == '0) || (emit && (rest == '0));
  assign col_ready = s2_free;
  assign load      = col_ctl.valid && s2_free;

  assign first_col                = (col_col == '0);
  assign first_row                = (col_row == '0);
  assign mask[RK_INTERIOR]        = !first_row && !first_col;
  assign mask[RK_RIGHT]           = !first_row && col_ctl.last_col;
  assign mask[RK_BOTTOM]          = col_ctl.last_row && !first_col;
  assign mask[RK_CORNER]          = col_ctl.last_row && col_ctl.last_col;

  always_comb begin
    if (load) begin
      pend_nxt = mask;
    end else if (emit) begin
      pend_nxt = rest;
    end else begin
      pend_nxt = pend_r;
    end
  end

  // A new row starts with its first column replicated across the window.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = first_col ? col_pix[i] : win_r[i][1];
      win_nxt[i][1] = first_col ? col_pix[i] : win_r[i][2];
      win_nxt[i][2] = col_pix[i];
    end
  end

  // Border results reuse the window with the bottom row or right column
  // standing in for the missing neighbor.
  always_comb begin
    case (kind)
      RK_INTERIOR: begin
        row_sh = 1'b0;
        col_sh = 1'b0;
      end
      RK_RIGHT: begin
        row_sh = 1'b0;
        col_sh = 1'b1;
      end
      RK_BOTTOM: begin
        row_sh = 1'b1;
        col_sh = 1'b0;
      end
      RK_CORNER: begin
        row_sh = 1'b1;
        col_sh = 1'b1;
      end
      default: begin
        row_sh = 1'b0;
        col_sh = 1'b0;
      end
    endcase
    rows_w[0] = row_sh ? win_r[1] : win_r[0];
    rows_w[1] = row_sh ? win_r[2] : win_r[1];
    rows_w[2] = win_r[2];
    for (int i = 0; i < 3; i++) begin
      eff_win[i][0] = col_sh ? rows_w[i][1] : rows_w[i][0];
      eff_win[i][1] = col_sh ? rows_w[i][2] : rows_w[i][1];
      eff_win[i][2] = rows_w[i][2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (load) begin
        win_r <= win_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_s2_r <= col_row;
      col_s2_r <= col_col;
    end
    if (emit) begin
      out_mag_r  <= sobel_mag(eff_win);
      out_row_r  <= (kind == RK_INTERIOR || kind == RK_RIGHT) ?
                    row_s2_r - ROW_W'(1) : row_s2_r;
      out_col_r  <= (kind == RK_INTERIOR || kind == RK_BOTTOM) ?
                    col_s2_r - COL_W'(1) : col_s2_r;
      out_last_r <= (rest == '0);
      out_eof_r  <= (kind == RK_CORNER);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_magnitude    = out_mag_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_last         = out_last_r;
  assign out_end_of_frame = out_eof_r;

endmodule

// ===== hw/rtl/sobel_edge_magnitude_3x3.sv =====
`timescale 1ns / 1ps
// 3x3 Sobel edge magnitude, floor(|Gx|/8) + floor(|Gy|/8), over 8-bit grey
// pixels in raster order, with replicated borders. One pixel item is taken
// per clock cycle while in_ready is high; the two rows above live in a
// single line RAM of MAX_WIDTH entries that is read at most once and
// written at most once per cycle. Results for row r-1 come out while row r
// streams in, one column behind; the last column and the last row come out
// beside later pixels, so one pixel causes zero to four results and the
// result port, at one result per cycle while out_ready is high, sets the
// pace on the last row (two results per pixel there). A pixel is registered
// in the fetch stage, then in the window stage, and each result is
// registered at the output port. Each result carries its row and column,
// last marks the final result of a pixel and end_of_frame the bottom-right
// one. The user must write width and height only while the block is idle;
// the block itself does not enforce it. Zero counts as one and the width is capped at MAX_WIDTH.
module sobel_edge_magnitude_3x3 import sem_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MAG_W-1:0]      out_magnitude,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]      out_col,
  output logic                  out_last,
  output logic                  out_end_of_frame
);

  col_ctl_t          col_ctl;
  logic              col_ready;
  pix_col_t          col_pix;
  logic [ROW_W-1:0]  col_row;
  logic [COL_W-1:0]  col_col;

  sem_line_fetch #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_fetch (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel),
    .col_ctl  (col_ctl),
    .col_ready(col_ready),
    .col_pix  (col_pix),
    .col_row  (col_row),
    .col_col  (col_col)
  );

  sem_window_out #(
    .COL_W(COL_W)
  ) u_window_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .col_ctl         (col_ctl),
    .col_ready       (col_ready),
    .col_pix         (col_pix),
    .col_row         (col_row),
    .col_col         (col_col),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_magnitude   (out_magnitude),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last        (out_last),
    .out_end_of_frame(out_end_of_frame)
  );

endmodule

// ===== hw/rtl/sem_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sem_checker import sem_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [MAG_W-1:0]   out_magnitude,
  input logic [ROW_W-1:0]   out_row,
  input logic [COL_W-1:0]   out_col,
  input logic               out_last,
  input logic               out_end_of_frame
);

  localparam logic [MAG_W-1:0] MaxMag = MAG_W'(254);

  // The bottom-right result is always the final one of its pixel.
  `SEM_ASSERT_IMM(a_eof_is_last, clk, rst_n, out_valid && out_end_of_frame, out_last)

  // Two gradients divided by eight never exceed 127 each.
  `SEM_ASSERT_IMM(a_mag_range, clk, rst_n, out_valid, out_magnitude <= MaxMag)

  `SEM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_magnitude) && $stable(out_row) && $stable(out_col) && $stable(out_last) && $stable(out_end_of_frame))

endmodule

bind sobel_edge_magnitude_3x3 sem_checker #(.MAX_WIDTH(MAX_WIDTH)) u_sem_checker (.*);
